FILE: hdl/hrhp_pkg.sv
// ---------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the http response header parser
// Holds the item structs, the controller/datapath command and status groups,
// the header prefix tables and small byte classification functions.
// ---------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

    // input word
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    // output word
    typedef struct packed {
        logic        record_kind;
        logic [15:0] status_code;
        logic        header_done;
        logic [31:0] content_length;
        logic [5:0]  etag_length;
        logic [7:0]  etag_byte;
        logic        last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic ld_etag;
        logic idx_inc;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic etag_hit;
        logic etag_last;
    } t_sts;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;
    localparam logic REC_STATUS   = 1'b0;
    localparam logic REC_ETAG     = 1'b1;

    localparam int CL_LEN = 16;
    localparam int ET_LEN = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // lower-case prefix tables
    localparam logic [7:0] CL_PREFIX [CL_LEN] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };
    localparam logic [7:0] ET_PREFIX [8] = '{
        8'h65, 8'h74, 8'h61, 8'h67, 8'h3A, 8'h20, 8'h00, 8'h00
    };

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hrhp_ram.sv
// ---------------------------------------------------------------------------
// hrhp_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module hrhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/hrhp_ctrl.sv
// ---------------------------------------------------------------------------
// hrhp_ctrl: controller of the http response header parser
// Runs the input/output handshakes and sequences the etag value reads.
// ---------------------------------------------------------------------------
`default_nettype none

module hrhp_ctrl
    import hrhp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EM   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   slot_free;

    assign slot_free = !r_ovalid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = slot_free;
                if (i_in_valid && slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.etag_hit) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EM;
            end
            S_EM: begin
                if (slot_free) begin
                    o_cmd.ld_etag = 1'b1;
                    if (i_sts.etag_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.step || o_cmd.ld_etag) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");
    a_rd_then_em: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_EM))
        else $error("read state not followed by emit");
    a_hit_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.etag_hit) |=> (r_state == S_RD))
        else $error("etag line end did not start reads");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step || o_cmd.ld_etag) |=> o_out_valid)
        else $error("loaded word not valid");
`endif

endmodule

`default_nettype wire

FILE: hdl/hrhp_dpath.sv
// ---------------------------------------------------------------------------
// hrhp_dpath: datapath of the http response header parser
// Parser state, line store, running prefix match, running number conversion
// and the output word register.
// ---------------------------------------------------------------------------
`default_nettype none

module hrhp_dpath
    import hrhp_pkg::*;
#(
    parameter int LINE_BYTES = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_cmd     i_cmd,
    output t_sts          o_sts,
    output t_out_item     o_out
);

    localparam int CAP = LINE_BYTES - 1;
    localparam int LW  = $clog2(LINE_BYTES);
    localparam int AW  = $clog2(CAP);

    localparam logic [1:0] CV_WS   = 2'd0;
    localparam logic [1:0] CV_DIG  = 2'd1;
    localparam logic [1:0] CV_STOP = 2'd2;

    logic [1:0]    r_spc, n_spc;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_prev, n_prev;
    logic [1:0]    r_run, n_run;
    logic          r_hf, n_hf;
    logic [15:0]   r_status, n_status;
    logic [31:0]   r_length, n_length;
    logic          r_mcl, n_mcl;
    logic          r_met, n_met;
    logic [1:0]    r_cph, n_cph;
    logic          r_neg, n_neg;
    logic [31:0]   r_mag, n_mag;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_elen, n_elen;
    t_out_item     r_out, n_out;

    logic [7:0]    c;
    logic          status_phase, eol, hit, app, can_app, conv_on;
    logic [31:0]   lim, conv_val;
    logic [35:0]   mag10;
    logic [31:0]   mag_sat;
    logic [LW-1:0] rd_sum;
    logic [7:0]    rdata;

    assign c            = i_item.data_byte;
    assign status_phase = (r_status == 16'd0);
    assign eol          = (c == CH_LF) || (c == CH_CR);
    assign can_app      = (r_len < LW'(CAP));
    assign conv_on      = status_phase || (r_len >= LW'(CL_LEN));

    // etag line end on the offered word
    assign hit = (i_item.kind == KIND_DATA) && !status_phase && eol && r_met
                 && (r_len >= LW'(ET_LEN));

    // converted value of the digits seen so far
    always_comb begin
        lim = status_phase ? 32'h0000_8000 : 32'h8000_0000;
        if (r_neg) begin
            conv_val = 32'd0 - r_mag;
        end else if (r_mag >= lim) begin
            conv_val = lim - 32'd1;
        end else begin
            conv_val = r_mag;
        end
        mag10   = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) + {32'd0, c[3:0]};
        mag_sat = (mag10 > {4'd0, lim}) ? lim : mag10[31:0];
    end

    // parser state update
    always_comb begin
        n_spc    = r_spc;
        n_len    = r_len;
        n_prev   = r_prev;
        n_run    = r_run;
        n_hf     = r_hf;
        n_status = r_status;
        n_length = r_length;
        n_mcl    = r_mcl;
        n_met    = r_met;
        n_cph    = r_cph;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_idx    = r_idx;
        n_elen   = r_elen;
        app      = 1'b0;

        if (i_cmd.step) begin
            n_idx = '0;
            if (i_item.kind == KIND_RESTART) begin
                n_spc    = '0;
                n_len    = '0;
                n_prev   = '0;
                n_run    = '0;
                n_hf     = 1'b0;
                n_status = '0;
            end else if (status_phase) begin
                if (r_spc < 2'd2) begin
                    if (c == CH_SPACE) begin
                        n_spc = r_spc + 2'd1;
                        if (r_spc == 2'd1) begin
                            n_status = conv_val[15:0];
                        end
                        n_len = '0;
                    end else begin
                        app = can_app;
                    end
                end
            end else begin
                if (eol) begin
                    if (c == CH_LF && (r_prev == CH_CR || r_prev == CH_LF)) begin
                        if (r_run < 2'd3) begin
                            n_run = r_run + 2'd1;
                        end
                        if (r_run == 2'd1) begin
                            n_hf = 1'b1;
                        end
                    end
                    if (r_mcl && r_len >= LW'(CL_LEN)) begin
                        n_length = conv_val;
                    end
                    if (hit) begin
                        n_elen = r_len - LW'(ET_LEN);
                    end
                    n_len = '0;
                end else begin
                    n_run = '0;
                    app   = can_app;
                end
                n_prev = c;
            end

            // new line: restart matching and conversion
            if (n_len == '0 && !app) begin
                n_mcl = 1'b1;
                n_met = 1'b1;
                n_cph = CV_WS;
                n_neg = 1'b0;
                n_mag = '0;
            end
        end

        if (i_cmd.idx_inc) begin
            n_idx = r_idx + LW'(1);
        end

        // stored byte feeds the prefix match and the conversion
        if (app) begin
            n_len = r_len + LW'(1);
            if (r_len < LW'(CL_LEN)) begin
                n_mcl = r_mcl && (to_lower(c) == CL_PREFIX[r_len[3:0]]);
            end
            if (r_len < LW'(ET_LEN)) begin
                n_met = r_met && (to_lower(c) == ET_PREFIX[r_len[2:0]]);
            end
            if (conv_on) begin
                case (r_cph)
                    CV_WS: begin
                        if (is_space(c)) begin
                            n_cph = CV_WS;
                        end else if (c == CH_PLUS || c == CH_MINUS) begin
                            n_cph = CV_DIG;
                            n_neg = (c == CH_MINUS);
                        end else if (is_digit(c)) begin
                            n_cph = CV_DIG;
                            n_mag = mag_sat;
                        end else begin
                            n_cph = CV_STOP;
                        end
                    end
                    CV_DIG: begin
                        if (is_digit(c)) begin
                            n_mag = mag_sat;
                        end else begin
                            n_cph = CV_STOP;
                        end
                    end
                    default: begin
                        n_cph = CV_STOP;
                    end
                endcase
            end
        end
    end

    // output word
    always_comb begin
        n_out = r_out;
        if (i_cmd.step) begin
            n_out.record_kind    = REC_STATUS;
            n_out.status_code    = n_status;
            n_out.header_done    = n_hf;
            n_out.content_length = n_length;
            n_out.etag_length    = '0;
            n_out.etag_byte      = '0;
            n_out.last           = !hit;
        end else if (i_cmd.ld_etag) begin
            n_out.record_kind    = REC_ETAG;
            n_out.status_code    = r_status;
            n_out.header_done    = r_hf;
            n_out.content_length = r_length;
            n_out.etag_length    = 6'(r_elen);
            n_out.etag_byte      = (r_elen == '0) ? 8'd0 : rdata;
            n_out.last           = o_sts.etag_last;
        end
    end

    assign o_sts.etag_hit  = hit;
    assign o_sts.etag_last = ({1'b0, r_idx} + (LW + 1)'(1)) >= {1'b0, r_elen};

    // line store
    assign rd_sum = r_idx + LW'(ET_LEN);

    hrhp_ram #(
        .WIDTH (8),
        .DEPTH (CAP)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (app),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (c),
        .i_raddr (rd_sum[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spc    <= '0;
            r_len    <= '0;
            r_prev   <= '0;
            r_run    <= '0;
            r_hf     <= 1'b0;
            r_status <= '0;
            r_length <= '0;
            r_mcl    <= 1'b1;
            r_met    <= 1'b1;
            r_cph    <= CV_WS;
            r_neg    <= 1'b0;
            r_mag    <= '0;
            r_idx    <= '0;
            r_elen   <= '0;
        end else begin
            r_spc    <= n_spc;
            r_len    <= n_len;
            r_prev   <= n_prev;
            r_run    <= n_run;
            r_hf     <= n_hf;
            r_status <= n_status;
            r_length <= n_length;
            r_mcl    <= n_mcl;
            r_met    <= n_met;
            r_cph    <= n_cph;
            r_neg    <= n_neg;
            r_mag    <= n_mag;
            r_idx    <= n_idx;
            r_elen   <= n_elen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out = r_out;

`ifndef SYNTHESIS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAP))
        else $error("line length beyond store");
    a_spc_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spc <= 2'd2)
        else $error("space count beyond two");
    a_status_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.step) |=> $stable(r_status) && $stable(r_len))
        else $error("parser state moved without a word");
`endif

endmodule

`default_nettype wire

FILE: hdl/http_response_header_parser.sv
// ---------------------------------------------------------------------------
// http_response_header_parser: streaming http response header parser
// Ordinary bytes are taken one per cycle while the output slot is free, each
// giving one status word. A line ending that closes an "ETag: " header is
// followed by its value bytes, read back from the line store byte by byte
// through a read state and an emit state (registered ram port); no input is
// taken until the last one is out. Status code and content length are
// converted on the fly as bytes arrive, so no line-end pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module http_response_header_parser
    import hrhp_pkg::*;
#(
    parameter int LINE_BYTES = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // controller
    hrhp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    hrhp_dpath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out_data)
    );

endmodule

`default_nettype wire
